[src/ploto_pkg.sv]
`default_nettype none

package ploto_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SECOND  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POWERDOWN_SECONDS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ARM_DELAY_SECONDS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RECONNECT_ONE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECONNECT_TWO     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RECONNECT_THREE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RECONNECT_FOUR    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RECONNECT_FIVE    = 3'd7;

    // Register reset values
    localparam logic [7:0]  TICKS_PER_SECOND_RST  = 8'd50;
    localparam logic [9:0]  POWERDOWN_SECONDS_RST = 10'd920;
    localparam logic [15:0] ARM_DELAY_SECONDS_RST = 16'd10;
    localparam logic [15:0] RECONNECT_ONE_RST     = 16'd180;
    localparam logic [15:0] RECONNECT_TWO_RST     = 16'd300;
    localparam logic [15:0] RECONNECT_THREE_RST   = 16'd420;
    localparam logic [15:0] RECONNECT_FOUR_RST    = 16'd600;
    localparam logic [15:0] RECONNECT_FIVE_RST    = 16'd900;

    // Item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PIN  = 1'b1;

    // Clock rollover and saturation points
    localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0]  MINUTES_PER_HOUR   = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY      = 5'd24;
    localparam logic [15:0] SINCE_START_MAX    = 16'hFFFF;

    typedef struct packed {
        logic op;
        logic pin_level;
    } ploto_in_t;

    typedef struct packed {
        logic        link_enabled;
        logic        power_down;
        logic        wake_armed;
        logic [5:0]  clock_seconds;
        logic [5:0]  clock_minutes;
        logic [4:0]  clock_hours;
        logic [15:0] clock_days;
    } ploto_out_t;

endpackage

`default_nettype wire

[src/ploto_stream_if.sv]
`default_nettype none

interface ploto_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

`default_nettype wire

[src/pulse_programmed_link_off_timer_top.sv]
// Link-off timer with an uptime clock, programmed by pin pulses.
// item_in carries one item per handshake: a timer tick (op = 0) or a pin
// change (op = 1) with the sampled pin level. Every accepted item yields
// exactly one item on item_out: link state, power-down pulse, wake-armed
// flag and the uptime clock (seconds, minutes, hours, days) after the item.
// The item is captured in an input register, the state update runs as
// combinational counter increments and compares, and the result lands in
// an output register. Throughput is one item per cycle while item_out is
// not stalled, so consecutive items need no gap.
// When item_out is stalled, the output register holds its item and the
// input register takes one more item, after which item_in.ready drops.
// Reset clears all counters, turns the link off and restores the
// configuration registers to their defaults. The APB port writes the
// configuration at byte address 4 * index; pready is always high and
// writes are expected only while no item is in flight.
`default_nettype none

module pulse_programmed_link_off_timer_top
    import ploto_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ploto_stream_if.sink               item_in,
    ploto_stream_if.source             item_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Configuration
    logic [7:0]  ticks_per_second_reg;
    logic [9:0]  powerdown_seconds_reg;
    logic [15:0] arm_delay_seconds_reg;
    logic [15:0] reconnect_one_reg;
    logic [15:0] reconnect_two_reg;
    logic [15:0] reconnect_three_reg;
    logic [15:0] reconnect_four_reg;
    logic [15:0] reconnect_five_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Handshake stages
    logic       in_valid_reg;
    ploto_in_t  in_data_reg;
    logic       out_valid_reg;
    ploto_out_t out_data_reg;
    logic       advance;

    // Timer state
    logic [7:0]  tick_prescale_reg,  tick_prescale_next;
    logic [5:0]  sec_count_reg,      sec_count_next;
    logic [5:0]  min_count_reg,      min_count_next;
    logic [4:0]  hour_count_reg,     hour_count_next;
    logic [15:0] day_count_reg,      day_count_next;
    logic [15:0] since_start_reg,    since_start_next;
    logic [9:0]  idle_seconds_reg,   idle_seconds_next;
    logic [15:0] reconnect_left_reg, reconnect_left_next;
    logic [7:0]  grace_left_reg,     grace_left_next;
    logic [7:0]  pulse_count_reg,    pulse_count_next;
    logic        link_on_reg,        link_on_next;
    logic        awake_flag_reg,     awake_flag_next;
    logic        armed_flag_reg,     armed_flag_next;
    logic        power_down_next;
    logic [15:0] reconnect_sel;

    // ------------------------------------------------------------------
    // APB configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_second_reg  <= TICKS_PER_SECOND_RST;
            powerdown_seconds_reg <= POWERDOWN_SECONDS_RST;
            arm_delay_seconds_reg <= ARM_DELAY_SECONDS_RST;
            reconnect_one_reg     <= RECONNECT_ONE_RST;
            reconnect_two_reg     <= RECONNECT_TWO_RST;
            reconnect_three_reg   <= RECONNECT_THREE_RST;
            reconnect_four_reg    <= RECONNECT_FOUR_RST;
            reconnect_five_reg    <= RECONNECT_FIVE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_TICKS_PER_SECOND:  ticks_per_second_reg  <= pwdata[7:0];
                REG_POWERDOWN_SECONDS: powerdown_seconds_reg <= pwdata[9:0];
                REG_ARM_DELAY_SECONDS: arm_delay_seconds_reg <= pwdata[15:0];
                REG_RECONNECT_ONE:     reconnect_one_reg     <= pwdata[15:0];
                REG_RECONNECT_TWO:     reconnect_two_reg     <= pwdata[15:0];
                REG_RECONNECT_THREE:   reconnect_three_reg   <= pwdata[15:0];
                REG_RECONNECT_FOUR:    reconnect_four_reg    <= pwdata[15:0];
                REG_RECONNECT_FIVE:    reconnect_five_reg    <= pwdata[15:0];
                default:               ticks_per_second_reg  <= ticks_per_second_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TICKS_PER_SECOND:  prdata = {24'd0, ticks_per_second_reg};
            REG_POWERDOWN_SECONDS: prdata = {22'd0, powerdown_seconds_reg};
            REG_ARM_DELAY_SECONDS: prdata = {16'd0, arm_delay_seconds_reg};
            REG_RECONNECT_ONE:     prdata = {16'd0, reconnect_one_reg};
            REG_RECONNECT_TWO:     prdata = {16'd0, reconnect_two_reg};
            REG_RECONNECT_THREE:   prdata = {16'd0, reconnect_three_reg};
            REG_RECONNECT_FOUR:    prdata = {16'd0, reconnect_four_reg};
            REG_RECONNECT_FIVE:    prdata = {16'd0, reconnect_five_reg};
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input and output registers
    // ------------------------------------------------------------------
    assign advance       = in_valid_reg && (!out_valid_reg || item_out.ready);
    assign item_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
            begin
                in_valid_reg <= item_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (item_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            in_data_reg <= item_in.payload;
        end
        if (advance)
        begin
            out_data_reg.link_enabled  <= link_on_next;
            out_data_reg.power_down    <= power_down_next;
            out_data_reg.wake_armed    <= armed_flag_next;
            out_data_reg.clock_seconds <= sec_count_next;
            out_data_reg.clock_minutes <= min_count_next;
            out_data_reg.clock_hours   <= hour_count_next;
            out_data_reg.clock_days    <= day_count_next;
        end
    end

    assign item_out.valid   = out_valid_reg;
    assign item_out.payload = out_data_reg;

    // ------------------------------------------------------------------
    // State update for the item in the input register
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (pulse_count_reg)
            8'd1:    reconnect_sel = reconnect_one_reg;
            8'd2:    reconnect_sel = reconnect_two_reg;
            8'd3:    reconnect_sel = reconnect_three_reg;
            8'd4:    reconnect_sel = reconnect_four_reg;
            8'd5:    reconnect_sel = reconnect_five_reg;
            default: reconnect_sel = 16'd0;
        endcase
    end

    always_comb
    begin
        tick_prescale_next  = tick_prescale_reg;
        sec_count_next      = sec_count_reg;
        min_count_next      = min_count_reg;
        hour_count_next     = hour_count_reg;
        day_count_next      = day_count_reg;
        since_start_next    = since_start_reg;
        idle_seconds_next   = idle_seconds_reg;
        reconnect_left_next = reconnect_left_reg;
        grace_left_next     = grace_left_reg;
        pulse_count_next    = pulse_count_reg;
        link_on_next        = link_on_reg;
        awake_flag_next     = awake_flag_reg;
        armed_flag_next     = armed_flag_reg;
        power_down_next     = 1'b0;

        if (in_data_reg.op == OP_PIN)
        begin
            awake_flag_next = 1'b1;
            if (!in_data_reg.pin_level)
            begin
                grace_left_next  = grace_left_reg + 8'd1;
                pulse_count_next = pulse_count_reg + 8'd1;
            end
        end
        else
        begin
            tick_prescale_next = tick_prescale_reg + 8'd1;
            // Activity since the last tick restarts the idle count
            if (awake_flag_reg)
            begin
                awake_flag_next   = 1'b0;
                idle_seconds_next = 10'd0;
            end

            if (tick_prescale_next == ticks_per_second_reg)
            begin
                tick_prescale_next = 8'd0;
                if (since_start_reg != SINCE_START_MAX)
                begin
                    since_start_next = since_start_reg + 16'd1;
                end
                sec_count_next      = sec_count_reg + 6'd1;
                idle_seconds_next   = idle_seconds_next + 10'd1;
                reconnect_left_next = reconnect_left_reg - 16'd1;
                if (reconnect_left_reg == 16'd0 && !link_on_reg)
                begin
                    link_on_next        = 1'b1;
                    reconnect_left_next = 16'd0;
                end
                // Grace expired: pulses counted while the link is on switch it off
                if (grace_left_reg == 8'd0)
                begin
                    if (pulse_count_reg != 8'd0 && link_on_next)
                    begin
                        reconnect_left_next = reconnect_sel;
                        link_on_next        = 1'b0;
                        pulse_count_next    = 8'd0;
                    end
                end
                else
                begin
                    grace_left_next = grace_left_reg - 8'd1;
                end
                if (since_start_next >= arm_delay_seconds_reg)
                begin
                    armed_flag_next = 1'b1;
                end
            end

            if (sec_count_next == SECONDS_PER_MINUTE)
            begin
                sec_count_next = 6'd0;
                min_count_next = min_count_reg + 6'd1;
            end
            if (min_count_next == MINUTES_PER_HOUR)
            begin
                min_count_next  = 6'd0;
                hour_count_next = hour_count_reg + 5'd1;
            end
            if (hour_count_next == HOURS_PER_DAY)
            begin
                hour_count_next = 5'd0;
                day_count_next  = day_count_reg + 16'd1;
            end
            if (idle_seconds_next == powerdown_seconds_reg)
            begin
                idle_seconds_next = 10'd0;
                power_down_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_prescale_reg  <= 8'd0;
            sec_count_reg      <= 6'd0;
            min_count_reg      <= 6'd0;
            hour_count_reg     <= 5'd0;
            day_count_reg      <= 16'd0;
            since_start_reg    <= 16'd0;
            idle_seconds_reg   <= 10'd0;
            reconnect_left_reg <= 16'd0;
            grace_left_reg     <= 8'd0;
            pulse_count_reg    <= 8'd0;
            link_on_reg        <= 1'b0;
            awake_flag_reg     <= 1'b0;
            armed_flag_reg     <= 1'b0;
        end
        else if (advance)
        begin
            tick_prescale_reg  <= tick_prescale_next;
            sec_count_reg      <= sec_count_next;
            min_count_reg      <= min_count_next;
            hour_count_reg     <= hour_count_next;
            day_count_reg      <= day_count_next;
            since_start_reg    <= since_start_next;
            idle_seconds_reg   <= idle_seconds_next;
            reconnect_left_reg <= reconnect_left_next;
            grace_left_reg     <= grace_left_next;
            pulse_count_reg    <= pulse_count_next;
            link_on_reg        <= link_on_next;
            awake_flag_reg     <= awake_flag_next;
            armed_flag_reg     <= armed_flag_next;
        end
    end

`ifndef SYNTHESIS
    // A pin-change item never produces a power-down pulse
    a_pin_no_powerdown: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.op == OP_PIN |=> !out_data_reg.power_down)
        else $error("power_down raised on a pin-change item");

    // The link only switches off through the link-off step, which drops the pulses
    a_link_off_clears_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(link_on_reg) |-> pulse_count_reg == 8'd0)
        else $error("link switched off without clearing the pulse count");

    // Wake arming is sticky
    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        armed_flag_reg |=> armed_flag_reg)
        else $error("wake_armed dropped");

    // Clock fields stay in range on every delivered item
    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.clock_seconds < SECONDS_PER_MINUTE
                           && out_data_reg.clock_minutes < MINUTES_PER_HOUR
                           && out_data_reg.clock_hours < HOURS_PER_DAY))
        else $error("uptime clock field out of range");
`endif

endmodule

`default_nettype wire
